/* rtl/rpeg_pkg.sv */
package rpeg_pkg;

   localparam int COORD_W     = 32;
   localparam int ANG_W       = 32;
   localparam int SIDES_W     = 7;
   localparam int CORDIC_W    = 54;
   localparam int MUL_RES_W   = 52;
   localparam int SUM_W       = 56;
   localparam int DIV_DVD_W   = 64;
   localparam int DIV_DSR_W   = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0]        KINV_Q30  = 32'd652032874;
   localparam logic [SIDES_W-1:0] MIN_SIDES = 7'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] tx;
      logic signed [COORD_W-1:0] ty;
      logic [SIDES_W-1:0]        sides;
   } item_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_DIV_N,
      B_TAN_ROT,
      B_TAN_DIV,
      B_MUL_FX,
      B_MUL_FY,
      B_MUL_VX,
      B_MUL_VY,
      B_EDGE,
      B_OUT
   } back_state_type;

   typedef enum logic {
      SHIFT_Q30,
      SHIFT_Q14
   } mul_shift_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] k);
      logic [31:0] v;
      unique case (k)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   function automatic logic [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v > SUM_W'(64'sd2147483647)) begin
         r = 32'h7FFFFFFF;
      end else if (v < -SUM_W'(64'sd2147483648)) begin
         r = 32'h80000000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/rpeg_front.sv */
module rpeg_front import rpeg_pkg::*; #(
   parameter int MAX_SIDES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [127:0]       req_tdata,
   input  logic [1:0]         req_tuser,
   input  logic               csr_wr_en,
   input  logic [SIDES_W-1:0] csr_wr_data,
   output logic               q_valid,
   output item_type           q_item,
   input  logic               q_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [SIDES_W-1:0] MAX_N = SIDES_W'(MAX_SIDES);

   logic [SIDES_W-1:0] sides_ff, sides_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   item_type           mem_ff [QUEUE_DEPTH];
   item_type           entry;
   logic               keep, push;

   // Items with an invalid point or too few sides are dropped here.
   always_comb begin
      keep = req_tuser[0] & req_tuser[1] & (sides_ff >= MIN_SIDES);
      entry.cx = req_tdata[31:0];
      entry.cy = req_tdata[63:32];
      entry.tx = req_tdata[95:64];
      entry.ty = req_tdata[127:96];
      entry.sides = (sides_ff > MAX_N) ? MAX_N : sides_ff;
   end

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid & req_tready & keep;
   assign q_valid    = (count_ff != '0);
   assign q_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      sides_in  = csr_wr_en ? csr_wr_data : sides_ff;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sides_ff  <= MIN_SIDES;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         sides_ff  <= sides_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

/* rtl/rpeg_cordic.sv */
module rpeg_cordic import rpeg_pkg::*; #(
   parameter int STEPS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [CORDIC_W-1:0] x_start,
   input  logic signed [CORDIC_W-1:0] y_start,
   input  logic [ANG_W-1:0]           angle,
   output logic                       done,
   output logic signed [CORDIC_W-1:0] x_out,
   output logic signed [CORDIC_W-1:0] y_out
);

   localparam int K_W = $clog2(STEPS);
   localparam int Z_W = ANG_W + 2;

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [Z_W-1:0]      z_ff, z_in, at;
   logic [K_W-1:0]             k_ff, k_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [1:0]                 quad;
   logic [ANG_W-1:0]           resid, ang_bias;

   always_comb begin
      ang_bias = angle + 32'h20000000;
      quad     = ang_bias[31:30];
      resid    = angle - {quad, 30'b0};
      xs       = x_ff >>> k_ff;
      ys       = y_ff >>> k_ff;
      at       = Z_W'(atan_entry(5'(k_ff)));
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      k_in     = k_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         // The quadrant part of the angle is applied exactly.
         unique case (quad)
            2'd0: begin x_in = x_start;  y_in = y_start;  end
            2'd1: begin x_in = -y_start; y_in = x_start;  end
            2'd2: begin x_in = -x_start; y_in = -y_start; end
            default: begin x_in = y_start; y_in = -x_start; end
         endcase
         z_in    = Z_W'(signed'(resid));
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         k_in = k_ff + 1'b1;
         if (k_ff == K_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      k_ff <= k_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;

endmodule

/* rtl/rpeg_div.sv */
module rpeg_div import rpeg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_DVD_W-1:0] dividend,
   input  logic [DIV_DSR_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_DVD_W-1:0] quotient,
   output logic [DIV_DSR_W-1:0] remainder
);

   localparam int C_W = $clog2(DIV_DVD_W);

   logic [DIV_DVD_W-1:0] dvd_ff, dvd_in;
   logic [DIV_DSR_W-1:0] dsr_ff, dsr_in, rem_ff, rem_in;
   logic [DIV_DSR_W:0]   rem_sh;
   logic [C_W-1:0]       cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   // Restoring division, one quotient bit a cycle; quotient bits fill dvd_ff.
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DIV_DVD_W-1]};
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = DIV_DSR_W'(rem_sh - {1'b0, dsr_ff});
            dvd_in = {dvd_ff[DIV_DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_DSR_W-1:0];
            dvd_in = {dvd_ff[DIV_DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == C_W'(DIV_DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/rpeg_mul.sv */
module rpeg_mul import rpeg_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [COORD_W:0]     a,
   input  logic [31:0]                 b,
   input  mul_shift_type               shift,
   output logic                        done,
   output logic signed [MUL_RES_W-1:0] product
);

   localparam int ACC_W = 2 * COORD_W + 1;

   logic [ACC_W-1:0] acc_ff, acc_in, mag_ff, mag_in, rounded;
   logic [31:0]      b_ff, b_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   mul_shift_type    shift_ff, shift_in;
   logic [MUL_RES_W-2:0] mag_res;

   // Shift-and-add on the magnitude, one multiplier bit a cycle.
   always_comb begin
      acc_in   = acc_ff;
      mag_in   = mag_ff;
      b_in     = b_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      shift_in = shift_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = '0;
         mag_in   = ACC_W'(a[COORD_W] ? -a : a);
         b_in     = b;
         cnt_in   = '0;
         neg_in   = a[COORD_W];
         shift_in = shift;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + mag_ff;
         end
         mag_in = mag_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Magnitude rounded half up, then the sign is put back.
   always_comb begin
      unique case (shift_ff)
         SHIFT_Q30: rounded = (acc_ff + (ACC_W'(1) << 29)) >> 30;
         default:   rounded = (acc_ff + (ACC_W'(1) << 13)) >> 14;
      endcase
      mag_res = rounded[MUL_RES_W-2:0];
      product = neg_ff ? -signed'({1'b0, mag_res}) : signed'({1'b0, mag_res});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mag_ff   <= mag_in;
      b_ff     <= b_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      shift_ff <= shift_in;
   end

   assign done = done_ff;

endmodule

/* rtl/rpeg_back.sv */
module rpeg_back import rpeg_pkg::*; #(
   parameter int CORDIC_STEPS = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  item_type     q_item,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,
   output logic         rsp_tlast
);

   back_state_type state_ff, state_in;
   logic           run_ff, run_in;

   item_type                    item_ff, item_in;
   logic [ANG_W-1:0]            qu_ff, qu_in, acc_ff, acc_in;
   logic [SIDES_W-1:0]          ru_ff, ru_in, arem_ff, arem_in, idx_ff, idx_in;
   logic [31:0]                 sn_ff, sn_in, cs_ff, cs_in, tq_ff, tq_in;
   logic [COORD_W-1:0]          fx_ff, fx_in, fy_ff, fy_in;
   logic [COORD_W-1:0]          vert_x_ff, vert_x_in, vert_y_ff, vert_y_in;
   logic [COORD_W-1:0]          nxt_x_ff, nxt_x_in, nxt_y_ff, nxt_y_in;
   logic signed [MUL_RES_W-1:0] vx_ff, vx_in, vy_ff, vy_in;

   logic                        div_start, div_done;
   logic [DIV_DVD_W-1:0]        div_dvd, div_quo;
   logic [DIV_DSR_W-1:0]        div_dsr, div_rem;
   logic                        cor_start, cor_done;
   logic signed [CORDIC_W-1:0]  cor_x0, cor_y0, cor_x, cor_y;
   logic [ANG_W-1:0]            cor_ang;
   logic                        mul_start, mul_done;
   logic signed [COORD_W:0]     mul_a;
   logic [31:0]                 mul_b;
   mul_shift_type               mul_shift;
   logic signed [MUL_RES_W-1:0] mul_res;

   logic                        is_last, any_start;
   logic [SIDES_W:0]            rsum;
   logic signed [SUM_W-1:0]     ex, ey;

   rpeg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   rpeg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .x_start (cor_x0),
      .y_start (cor_y0),
      .angle   (cor_ang),
      .done    (cor_done),
      .x_out   (cor_x),
      .y_out   (cor_y)
   );

   rpeg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .shift   (mul_shift),
      .done    (mul_done),
      .product (mul_res)
   );

   assign is_last = (({1'b0, idx_ff} + 1'b1) == {1'b0, item_ff.sides});

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:    if (q_valid) state_in = B_DIV_N;
         B_DIV_N:   if (div_done) state_in = B_TAN_ROT;
         B_TAN_ROT: if (cor_done) state_in = B_TAN_DIV;
         B_TAN_DIV: if (div_done) state_in = B_MUL_FX;
         B_MUL_FX:  if (mul_done) state_in = B_MUL_FY;
         B_MUL_FY:  if (mul_done) state_in = B_MUL_VX;
         B_MUL_VX:  if (mul_done) state_in = B_MUL_VY;
         B_MUL_VY:  if (mul_done) state_in = B_EDGE;
         B_EDGE:    if (is_last || cor_done) state_in = B_OUT;
         B_OUT:     if (rsp_tready) state_in = is_last ? B_IDLE : B_EDGE;
         default:   state_in = B_IDLE;
      endcase
   end

   // Unit launches and operand selection.
   always_comb begin
      q_pop     = (state_ff == B_IDLE) && q_valid;
      div_start = ((state_ff == B_DIV_N) || (state_ff == B_TAN_DIV)) && !run_ff;
      cor_start = ((state_ff == B_TAN_ROT) || ((state_ff == B_EDGE) && !is_last)) && !run_ff;
      mul_start = ((state_ff == B_MUL_FX) || (state_ff == B_MUL_FY) ||
                   (state_ff == B_MUL_VX) || (state_ff == B_MUL_VY)) && !run_ff;
      any_start = div_start | cor_start | mul_start;
      run_in    = (state_in == state_ff) && (run_ff || any_start);

      if (state_ff == B_DIV_N) begin
         div_dvd = DIV_DVD_W'(64'h1_0000_0000);
         div_dsr = DIV_DSR_W'(item_ff.sides);
      end else begin
         div_dvd = ({32'b0, sn_ff} << 30) + {33'b0, cs_ff[31:1]};
         div_dsr = cs_ff;
      end

      if (state_ff == B_TAN_ROT) begin
         cor_x0  = CORDIC_W'(signed'({1'b0, KINV_Q30}));
         cor_y0  = '0;
         cor_ang = {1'b0, qu_ff[ANG_W-1:1]};
      end else begin
         cor_x0  = CORDIC_W'(vx_ff);
         cor_y0  = CORDIC_W'(vy_ff);
         cor_ang = acc_ff;
      end

      unique case (state_ff)
         B_MUL_FX: begin
            mul_a = (COORD_W+1)'(item_ff.cy) - (COORD_W+1)'(item_ff.ty);
            mul_b = tq_ff;
            mul_shift = SHIFT_Q30;
         end
         B_MUL_FY: begin
            mul_a = (COORD_W+1)'(item_ff.tx) - (COORD_W+1)'(item_ff.cx);
            mul_b = tq_ff;
            mul_shift = SHIFT_Q30;
         end
         B_MUL_VX: begin
            mul_a = (COORD_W+1)'(signed'(fx_ff)) - (COORD_W+1)'(item_ff.cx);
            mul_b = KINV_Q30;
            mul_shift = SHIFT_Q14;
         end
         default: begin
            mul_a = (COORD_W+1)'(signed'(fy_ff)) - (COORD_W+1)'(item_ff.cy);
            mul_b = KINV_Q30;
            mul_shift = SHIFT_Q14;
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      item_in   = item_ff;
      qu_in     = qu_ff;
      ru_in     = ru_ff;
      acc_in    = acc_ff;
      arem_in   = arem_ff;
      idx_in    = idx_ff;
      sn_in     = sn_ff;
      cs_in     = cs_ff;
      tq_in     = tq_ff;
      fx_in     = fx_ff;
      fy_in     = fy_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      vert_x_in = vert_x_ff;
      vert_y_in = vert_y_ff;
      nxt_x_in  = nxt_x_ff;
      nxt_y_in  = nxt_y_ff;
      rsum      = {1'b0, arem_ff} + {1'b0, ru_ff};
      ex = ((SUM_W'(cor_x) + SUM_W'(32768)) >>> 16) + SUM_W'(item_ff.cx);
      ey = ((SUM_W'(cor_y) + SUM_W'(32768)) >>> 16) + SUM_W'(item_ff.cy);
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               item_in = q_item;
               idx_in  = '0;
            end
         end
         B_DIV_N: begin
            // One step of the corner angle is 2^32/n as quotient and remainder.
            if (div_done) begin
               qu_in   = div_quo[ANG_W-1:0];
               ru_in   = div_rem[SIDES_W-1:0];
               acc_in  = div_quo[ANG_W-1:0];
               arem_in = div_rem[SIDES_W-1:0];
            end
         end
         B_TAN_ROT: begin
            if (cor_done) begin
               sn_in = (cor_y < 0) ? 32'd0 : cor_y[31:0];
               cs_in = (cor_x < 1) ? 32'd1 : cor_x[31:0];
            end
         end
         B_TAN_DIV: begin
            if (div_done) tq_in = div_quo[31:0];
         end
         B_MUL_FX: begin
            if (mul_done) fx_in = sat32(SUM_W'(item_ff.tx) + SUM_W'(mul_res));
         end
         B_MUL_FY: begin
            if (mul_done) fy_in = sat32(SUM_W'(item_ff.ty) + SUM_W'(mul_res));
         end
         B_MUL_VX: begin
            if (mul_done) vx_in = mul_res;
         end
         B_MUL_VY: begin
            if (mul_done) begin
               vy_in     = mul_res;
               vert_x_in = fx_ff;
               vert_y_in = fy_ff;
            end
         end
         B_EDGE: begin
            if (is_last) begin
               nxt_x_in = fx_ff;
               nxt_y_in = fy_ff;
            end else if (cor_done) begin
               nxt_x_in = sat32(ex);
               nxt_y_in = sat32(ey);
            end
         end
         B_OUT: begin
            if (rsp_tready) begin
               vert_x_in = nxt_x_ff;
               vert_y_in = nxt_y_ff;
               idx_in    = idx_ff + 1'b1;
               if (rsum >= {1'b0, item_ff.sides}) begin
                  arem_in = SIDES_W'(rsum - {1'b0, item_ff.sides});
                  acc_in  = acc_ff + qu_ff + 1'b1;
               end else begin
                  arem_in = rsum[SIDES_W-1:0];
                  acc_in  = acc_ff + qu_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         run_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      qu_ff     <= qu_in;
      ru_ff     <= ru_in;
      acc_ff    <= acc_in;
      arem_ff   <= arem_in;
      idx_ff    <= idx_in;
      sn_ff     <= sn_in;
      cs_ff     <= cs_in;
      tq_ff     <= tq_in;
      fx_ff     <= fx_in;
      fy_ff     <= fy_in;
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      vert_x_ff <= vert_x_in;
      vert_y_ff <= vert_y_in;
      nxt_x_ff  <= nxt_x_in;
      nxt_y_ff  <= nxt_y_in;
   end

   assign rsp_tvalid = (state_ff == B_OUT);
   assign rsp_tdata  = {nxt_y_ff, nxt_x_ff, vert_y_ff, vert_x_ff};
   assign rsp_tlast  = is_last;

endmodule

/* rtl/regular_polygon_edge_generator.sv */
// Before the first edge of a taken word, the back end runs two divisions, a
// CORDIC rotation for the tangent and four multiplies, one unit at a time.
// Each further corner takes one CORDIC rotation; the closing edge needs none. A new
// word is taken from the queue only once the last edge of the previous one is accepted.
// The input queue holds two words. Synchronous reset empties it, idles the
// back end and sets the side count to 3; no clearing pass is needed.
module regular_polygon_edge_generator import rpeg_pkg::*; #(
   parameter int MAX_SIDES    = 64,
   parameter int CORDIC_STEPS = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,    // center_x, center_y, tangent_x, tangent_y
   input  logic [1:0]   req_tuser,    // center_ok, tangent_ok
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,    // start_x, start_y, end_x, end_y
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data
);

   logic     q_valid, q_pop;
   item_type q_item;

   rpeg_front #(.MAX_SIDES(MAX_SIDES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   rpeg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue popped while empty");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_valid) else $error("queue full but shows no entry");

   a_gap_after_close: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("edge offered right after the closing edge");

endmodule

/* dv/tb_regular_polygon_edge_generator.sv */
`timescale 1ns / 100ps

import rpeg_pkg::*;

typedef struct {
   logic [31:0] sx;
   logic [31:0] sy;
   logic [31:0] ex;
   logic [31:0] ey;
   logic        last;
} edge_word_type;

class polygon_scoreboard;
   edge_word_type edge_q[$];
   logic [6:0]    side_count;
   int            errors;

   function new();
      side_count = 7'd3;
      errors     = 0;
   endfunction

   function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Product rounded half away from zero: round the magnitude, then restore the sign.
   function longint scaled_mul(longint a, longint unsigned b, int sh);
      longint unsigned m;
      longint unsigned p;
      m = (a < 0) ? longint'(-a) : longint'(a);
      p = (m * b + (64'd1 << (sh - 1))) >> sh;
      return (a < 0) ? -longint'(p) : longint'(p);
   endfunction

   function void cordic_rotate(inout longint x, inout longint y, input logic [31:0] ang);
      logic [31:0] q;
      logic [31:0] r;
      longint      z;
      longint      t;
      longint      xs;
      longint      ys;
      q = ((ang + 32'h20000000) >> 30) & 32'd3;
      r = ang - (q << 30);
      z = longint'(signed'(r));
      if (q == 1) begin
         t = x; x = -y; y = t;
      end else if (q == 2) begin
         x = -x; y = -y;
      end else if (q == 3) begin
         t = x; x = y; y = -t;
      end
      for (int k = 0; k < 20; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(atan_entry(5'(k)));
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(atan_entry(5'(k)));
         end
      end
   endfunction

   function void note_item(logic [31:0] cxw, logic [31:0] cyw, logic [31:0] txw,
                           logic [31:0] tyw, logic cok, logic tok);
      longint          cx, cy, tx, ty, cs, sn, fx, fy, vx, vy, dx, dy, nx, ny, px, py;
      longint unsigned n, tq, usn, ucs, ang;
      edge_word_type   w;
      cx = longint'(signed'(cxw)); cy = longint'(signed'(cyw));
      tx = longint'(signed'(txw)); ty = longint'(signed'(tyw));
      n  = side_count;
      if (!cok || !tok || n < 3) return;
      if (n > 64) n = 64;
      cs = longint'(KINV_Q30);
      sn = 0;
      cordic_rotate(cs, sn, 32'h80000000 / 32'(n));
      if (sn < 0) sn = 0;
      if (cs < 1) cs = 1;
      usn = sn;
      ucs = cs;
      tq  = ((usn << 30) + (ucs >> 1)) / ucs;
      fx = clamp32(tx + scaled_mul(cy - ty, tq, 30));
      fy = clamp32(ty + scaled_mul(tx - cx, tq, 30));
      vx = scaled_mul(fx - cx, longint'(KINV_Q30), 14);
      vy = scaled_mul(fy - cy, longint'(KINV_Q30), 14);
      px = fx;
      py = fy;
      for (longint unsigned i = 0; i < n; i++) begin
         if (i + 1 == n) begin
            nx = fx; ny = fy;
         end else begin
            dx  = vx; dy = vy;
            ang = ((i + 1) << 32) / n;
            cordic_rotate(dx, dy, ang[31:0]);
            nx = clamp32(cx + ((dx + 32768) >>> 16));
            ny = clamp32(cy + ((dy + 32768) >>> 16));
         end
         w.sx = px[31:0]; w.sy = py[31:0]; w.ex = nx[31:0]; w.ey = ny[31:0];
         w.last = (i + 1 == n);
         edge_q.push_back(w);
         px = nx; py = ny;
      end
   endfunction

   function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("edge %s wrong: got %h, want %h", what, got, want);
      errors++;
   endfunction

   function void check_edge(logic [127:0] data, logic last);
      edge_word_type w;
      if (edge_q.size() == 0) begin
         $display("unexpected edge %h last %b", data, last);
         errors++;
         return;
      end
      w = edge_q.pop_front();
      if (data[31:0] !== w.sx) report("start_x", data[31:0], w.sx);
      if (data[63:32] !== w.sy) report("start_y", data[63:32], w.sy);
      if (data[95:64] !== w.ex) report("end_x", data[95:64], w.ex);
      if (data[127:96] !== w.ey) report("end_y", data[127:96], w.ey);
      if (last !== w.last) report("last", 32'(last), 32'(w.last));
   endfunction
endclass

module tb_regular_polygon_edge_generator;
   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_wr_en = 0;
   logic [6:0]   csr_wr_data = '0;

   polygon_scoreboard sb = new();
   int  cycle_count = 0;
   int  hold_cycles = 0;
   int  stall_left = 0;
   bit  busy_sink = 0;
   int  words_sent = 0;

   regular_polygon_edge_generator dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 10000000) begin
         $display("regular_polygon_edge_generator: mismatch");
         $finish;
      end
   end

   // Result side: check accepted words, then decide ready for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_edge(rsp_tdata, rsp_tlast);
      if (cycle_count % 300 == 0) busy_sink = $urandom_range(0, 1);
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_tready <= 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
         if (busy_sink && $urandom_range(0, 3) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 3);
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'(signed'($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000);
         2: return 32'h7FFFFFFF - $urandom_range(0, 32'h0000FFFF);
         default: return 32'(signed'($urandom_range(0, 32'h0FFFFFFF)) - 32'sh08000000);
      endcase
   endfunction

   task automatic send_word(logic [31:0] cx, logic [31:0] cy, logic [31:0] tx,
                            logic [31:0] ty, logic cok, logic tok);
      int gap;
      req_tdata  <= {ty, tx, cy, cx};
      req_tuser  <= {tok, cok};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sb.note_item(cx, cy, tx, ty, cok, tok);
      words_sent++;
      gap = ($urandom_range(0, 2) == 0) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(30, 400) : $urandom_range(1, 4);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic [31:0] cx, cy, tx, ty;
      logic        cok, tok;
      cx = rand_coord(); cy = rand_coord();
      tx = ($urandom_range(0, 19) == 0) ? cx : rand_coord();
      ty = (tx == cx) ? cy : rand_coord();
      cok = ($urandom_range(0, 11) != 0);
      tok = ($urandom_range(0, 11) != 0);
      send_word(cx, cy, tx, ty, cok, tok);
   endtask

   // Invalid items produce nothing, so the block may still be busy once the queue drains.
   task automatic write_sides(logic [6:0] v);
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.edge_q.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.side_count = v;
   endtask

   initial begin
      logic [6:0] n;
      repeat (5) @(posedge clock);
      reset <= 0;
      repeat (3) @(posedge clock);

      // Directed: sides 3, 4, 0-2, 64, 127; extremes, coincident points, invalid flags.
      send_word(32'h00010000, 32'h00020000, 32'h00010000, 32'h00000000, 1, 1);
      send_word(32'h12345678, 32'h9ABCDEF0, 32'h12345678, 32'h9ABCDEF0, 1, 1);
      send_word(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1, 1);
      send_word(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1, 1);
      send_word(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000, 1, 1);
      send_word(32'h00010000, 32'h00010000, 32'h00050000, 32'h00030000, 0, 1);
      send_word(32'h00010000, 32'h00010000, 32'h00050000, 32'h00030000, 1, 0);
      send_word(32'h00010000, 32'h00010000, 32'h00050000, 32'h00030000, 0, 0);
      write_sides(7'd4);
      send_word(32'h00000000, 32'h00000000, 32'h00000000, 32'hFFF00000, 1, 1);
      send_word(32'h7FFF0000, 32'h7FFF0000, 32'h7FFE0000, 32'h7FFF0000, 1, 1);
      for (int k = 0; k < 3; k++) begin
         write_sides(7'(k));
         send_word(32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000, 1, 1);
      end
      write_sides(7'd64);
      send_word(32'h00100000, 32'hFFF00000, 32'h00200000, 32'hFFF80000, 1, 1);
      send_word(32'h80000000, 32'h80000000, 32'h80000001, 32'h80000000, 1, 1);
      write_sides(7'd127);
      send_word(32'h00000000, 32'h00000000, 32'h00010000, 32'h00000000, 1, 1);
      write_sides(7'd3);

      // Receiver holds off while the sender keeps offering, so the input stalls.
      hold_cycles = 4000;
      repeat (6) send_random();

      while (words_sent < 290) begin
         case ($urandom_range(0, 9))
            0: n = 7'($urandom_range(0, 2));
            1: n = 7'($urandom_range(13, 127));
            default: n = 7'($urandom_range(3, 12));
         endcase
         write_sides(n);
         repeat ((n > 12) ? 3 : 20) send_random();
      end

      req_tvalid <= 0;
      @(posedge clock);
      while (sb.edge_q.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (sb.errors == 0)
         $display("regular_polygon_edge_generator: match");
      else
         $display("regular_polygon_edge_generator: mismatch");
      $finish;
   end
endmodule

/* files.f */
rtl/rpeg_pkg.sv
rtl/rpeg_front.sv
rtl/rpeg_cordic.sv
rtl/rpeg_div.sv
rtl/rpeg_mul.sv
rtl/rpeg_back.sv
rtl/regular_polygon_edge_generator.sv
dv/tb_regular_polygon_edge_generator.sv
